### rtl/ali_pkg.sv
// Shared types and codes of the positional insert and remove list.
`timescale 1ns / 1ps

package ali_pkg;

  localparam int MODE_W  = 3;
  localparam int POS_W   = 11;
  localparam int DATA_W  = 32;
  localparam int COUNT_W = 11;

  typedef enum logic [MODE_W-1:0] {
    MODE_INS_FRONT = 3'd0,
    MODE_INS_BACK  = 3'd1,
    MODE_INS_AT    = 3'd2,
    MODE_REM_FRONT = 3'd3,
    MODE_REM_BACK  = 3'd4,
    MODE_REM_AT    = 3'd5,
    MODE_READ      = 3'd6
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_BAD  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SHIFT_UP,
    S_PUT,
    S_FETCH,
    S_GRAB,
    S_SHIFT_DOWN,
    S_RESP
  } state_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [POS_W-1:0]  position;
    logic [DATA_W-1:0] element_value;
  } req_t;

  typedef struct packed {
    logic [DATA_W-1:0]  removed_value;
    status_t            status;
    logic [COUNT_W-1:0] entry_count;
  } rsp_t;

endpackage

### rtl/ali_if.sv
// Valid/ready channels for list requests and list results.
`timescale 1ns / 1ps

interface ali_req_if;
  logic        valid;
  logic        ready;
  ali_pkg::req_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface ali_rsp_if;
  logic        valid;
  logic        ready;
  ali_pkg::rsp_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

### rtl/array_list_insert_remove.sv
// Top level of the bounded ordered list with positional insert and remove.
//
// Channels: req takes one request item (mode, position, element_value);
// rsp returns exactly one result item (removed_value, status, entry_count)
// for each request, in order. Both use valid/ready; an item moves at a
// clock edge where both are high.
// The list lives in one RAM of CAPACITY entries; entries are shifted one
// memory move per cycle through its single read and single write port.
// A rejected request goes straight to its result; an insert or remove also
// shifts the entries between position and the count. One request is in work
// at a time; req.ready is high when no request is in work, also while a
// finished result waits on rsp.
// Reset (rst, synchronous) empties the list and drops any pending result;
// the RAM is not cleared, since only entries below the count are read.
// When the receiver stalls, the result holds in the output register and a
// following request stops before loading its own result.
`timescale 1ns / 1ps

module array_list_insert_remove #(
  parameter int CAPACITY      = 1024,
  parameter int ELEMENT_WIDTH = 32
) (
  input  logic      clk,
  input  logic      rst,
  ali_req_if.sink   req,
  ali_rsp_if.source rsp
);

  localparam int AW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = (CNT_W > ali_pkg::POS_W) ? CNT_W : ali_pkg::POS_W;

  ali_pkg::state_t  state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic [CNT_W-1:0] ptr, ptr_next;
  logic [CNT_W-1:0] lim, lim_next;
  logic [AW-1:0]    rd_q, rd_q_next;
  logic             pend, pend_next;
  logic             is_read, is_read_next;
  logic [ELEMENT_WIDTH-1:0] val, val_next;
  logic [ELEMENT_WIDTH-1:0] res, res_next;
  ali_pkg::status_t res_status, res_status_next;
  ali_pkg::rsp_t    out, out_next;
  logic             out_valid, out_valid_next;
  logic             out_load;

  logic                     mem_we, mem_re;
  logic [AW-1:0]            mem_waddr, mem_raddr;
  logic [ELEMENT_WIDTH-1:0] mem_wdata, mem_rdata;

  logic             req_fire;
  logic             full, empty;
  logic [CMP_W-1:0] cnt_ext, pos_ext, p_sel;

  ali_ram #(
    .WIDTH (ELEMENT_WIDTH),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign req.ready   = (state == ali_pkg::S_IDLE);
  assign req_fire    = req.valid && req.ready;
  assign rsp.valid   = out_valid;
  assign rsp.payload = out;

  assign full    = (cnt == CNT_W'(CAPACITY));
  assign empty   = (cnt == '0);
  assign cnt_ext = CMP_W'(cnt);
  assign pos_ext = CMP_W'(req.payload.position);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ali_pkg::S_IDLE;
      cnt       <= '0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      pend      <= pend_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    ptr        <= ptr_next;
    lim        <= lim_next;
    rd_q       <= rd_q_next;
    is_read    <= is_read_next;
    val        <= val_next;
    res        <= res_next;
    res_status <= res_status_next;
    out        <= out_next;
  end

  always_comb begin
    state_next      = state;
    cnt_next        = cnt;
    ptr_next        = ptr;
    lim_next        = lim;
    rd_q_next       = rd_q;
    pend_next       = pend;
    is_read_next    = is_read;
    val_next        = val;
    res_next        = res;
    res_status_next = res_status;
    mem_we          = 1'b0;
    mem_waddr       = rd_q;
    mem_wdata       = mem_rdata;
    mem_re          = 1'b0;
    mem_raddr       = ptr[AW-1:0];
    out_load        = 1'b0;
    p_sel           = pos_ext;

    unique case (state)
      ali_pkg::S_IDLE: begin
        if (req_fire) begin
          res_next        = '0;
          res_status_next = ali_pkg::ST_OK;
          val_next        = ELEMENT_WIDTH'(req.payload.element_value);
          pend_next       = 1'b0;
          unique case (req.payload.mode)
            ali_pkg::MODE_INS_FRONT, ali_pkg::MODE_INS_BACK, ali_pkg::MODE_INS_AT: begin
              if (req.payload.mode == ali_pkg::MODE_INS_FRONT) begin
                p_sel = '0;
              end else if (req.payload.mode == ali_pkg::MODE_INS_BACK) begin
                p_sel = cnt_ext;
              end
              if (full) begin
                res_status_next = ali_pkg::ST_FULL;
                state_next      = ali_pkg::S_RESP;
              end else if (p_sel > cnt_ext) begin
                res_status_next = ali_pkg::ST_BAD;
                state_next      = ali_pkg::S_RESP;
              end else begin
                ptr_next   = cnt;
                lim_next   = p_sel[CNT_W-1:0];
                state_next = ali_pkg::S_SHIFT_UP;
              end
            end
            ali_pkg::MODE_REM_FRONT, ali_pkg::MODE_REM_BACK, ali_pkg::MODE_REM_AT,
            ali_pkg::MODE_READ: begin
              if (req.payload.mode == ali_pkg::MODE_REM_FRONT) begin
                p_sel = '0;
              end else if (req.payload.mode == ali_pkg::MODE_REM_BACK) begin
                p_sel = cnt_ext - CMP_W'(1);
              end
              is_read_next = (req.payload.mode == ali_pkg::MODE_READ);
              if (empty || p_sel >= cnt_ext) begin
                res_status_next = ali_pkg::ST_BAD;
                state_next      = ali_pkg::S_RESP;
              end else begin
                ptr_next   = p_sel[CNT_W-1:0];
                state_next = ali_pkg::S_FETCH;
              end
            end
            default: begin
              res_status_next = ali_pkg::ST_BAD;
              state_next      = ali_pkg::S_RESP;
            end
          endcase
        end
      end

      // Walk down from the tail: read entry i, write it to i + 1 next cycle.
      ali_pkg::S_SHIFT_UP: begin
        if (pend) begin
          mem_we    = 1'b1;
          mem_waddr = rd_q + AW'(1);
        end
        if (ptr > lim) begin
          mem_re    = 1'b1;
          mem_raddr = AW'(ptr - CNT_W'(1));
          rd_q_next = AW'(ptr - CNT_W'(1));
          ptr_next  = ptr - CNT_W'(1);
          pend_next = 1'b1;
        end else begin
          pend_next  = 1'b0;
          state_next = ali_pkg::S_PUT;
        end
      end

      ali_pkg::S_PUT: begin
        mem_we     = 1'b1;
        mem_waddr  = lim[AW-1:0];
        mem_wdata  = val;
        cnt_next   = cnt + CNT_W'(1);
        state_next = ali_pkg::S_RESP;
      end

      ali_pkg::S_FETCH: begin
        mem_re     = 1'b1;
        mem_raddr  = ptr[AW-1:0];
        ptr_next   = ptr + CNT_W'(1);
        state_next = ali_pkg::S_GRAB;
      end

      ali_pkg::S_GRAB: begin
        res_next   = mem_rdata;
        pend_next  = 1'b0;
        state_next = is_read ? ali_pkg::S_RESP : ali_pkg::S_SHIFT_DOWN;
      end

      // Walk up from the hole: read entry i, write it to i - 1 next cycle.
      ali_pkg::S_SHIFT_DOWN: begin
        if (pend) begin
          mem_we    = 1'b1;
          mem_waddr = rd_q - AW'(1);
        end
        if (ptr < cnt) begin
          mem_re    = 1'b1;
          mem_raddr = ptr[AW-1:0];
          rd_q_next = ptr[AW-1:0];
          ptr_next  = ptr + CNT_W'(1);
          pend_next = 1'b1;
        end else begin
          pend_next  = 1'b0;
          cnt_next   = cnt - CNT_W'(1);
          state_next = ali_pkg::S_RESP;
        end
      end

      ali_pkg::S_RESP: begin
        if (!out_valid || rsp.ready) begin
          out_load   = 1'b1;
          state_next = ali_pkg::S_IDLE;
        end
      end

      default: begin
        state_next = ali_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_next       = out;
    out_valid_next = out_valid;
    if (out_load) begin
      out_next.removed_value = ali_pkg::DATA_W'(res);
      out_next.status        = res_status;
      out_next.entry_count   = ali_pkg::COUNT_W'(cnt);
      out_valid_next         = 1'b1;
    end else if (rsp.ready) begin
      out_valid_next = 1'b0;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> state != ali_pkg::S_IDLE)
    else $error("store written with no request in work");

  a_shift_no_overlap: assert property (@(posedge clk) disable iff (rst)
    (mem_we && mem_re) |-> mem_waddr != mem_raddr)
    else $error("read and write hit the same entry");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    req_fire |=> state != ali_pkg::S_IDLE)
    else $error("accepted item left no work");

  a_full_flag: assert property (@(posedge clk) disable iff (rst)
    (out_load && res_status == ali_pkg::ST_FULL) |-> full)
    else $error("full status on a list with room");

endmodule

### rtl/ali_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module ali_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
